// ===== rtl/modbus_rtu_frame_check_assert.svh =====
// assertion macros shared by the frame check rtl
`ifndef MODBUS_RTU_FRAME_CHECK_ASSERT_SVH
`define MODBUS_RTU_FRAME_CHECK_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MRFC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MRFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mrfc_pkg.sv =====
// ----------------------------------------------------------------------------
// mrfc_pkg
// Shared constants, verdict codes and the byte-wide CRC-16 update for the
// Modbus RTU frame checker.
// ----------------------------------------------------------------------------
package mrfc_pkg;

  localparam int unsigned MAX_FRAME_DEF = 256;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned CRC_W         = 16;
  localparam int unsigned LEN_W         = 9;
  localparam int unsigned VERDICT_W     = 2;

  localparam logic [CRC_W-1:0]  CRC_POLY     = 16'hA001;
  localparam logic [CRC_W-1:0]  CRC_INIT     = 16'hFFFF;
  localparam logic [BYTE_W-1:0] OWN_ADDR_RST = 8'h01;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_OK       = 2'd0,
    VERDICT_CRC_ERR  = 2'd1,
    VERDICT_ADDR_ERR = 2'd2,
    VERDICT_LEN_ERR  = 2'd3
  } verdict_t;

  // reflected crc-16, one byte lsb first, unrolled
  function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/modbus_rtu_frame_check.sv =====
// ----------------------------------------------------------------------------
// modbus_rtu_frame_check
// Checks received Modbus RTU frames byte by byte and reports one verdict per
// frame: crc, own address and length.
// ----------------------------------------------------------------------------
// Takes one byte per clock unless stalled: the byte-wide CRC-16 update is a
// single unrolled XOR network, so each beat updates the frame state in the
// cycle it is accepted. A frame's verdict lands in the output register, shown
// from the next cycle, on the edge that accepts the byte marked last, or in
// the skid if that register holds an untaken verdict. The two newest bytes
// sit in a two-byte delay and are compared against the running CRC (low byte
// first). A one-entry skid stage behind the output register lets bytes keep
// flowing while a verdict waits; in_stall rises only once both the output
// register and the skid hold verdicts. Frames shorter than 3 bytes or longer
// than MAX_FRAME get a length error. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`include "modbus_rtu_frame_check_assert.svh"

module modbus_rtu_frame_check #(
  parameter int unsigned MAX_FRAME = mrfc_pkg::MAX_FRAME_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // config
  input  logic                            cfg_wr_en,
  input  logic [mrfc_pkg::BYTE_W-1:0]     cfg_wr_data,
  // byte input
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mrfc_pkg::BYTE_W-1:0]     in_data_byte,
  input  logic                            in_last_byte,
  // verdict output
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mrfc_pkg::VERDICT_W-1:0]  out_verdict,
  output logic [mrfc_pkg::LEN_W-1:0]      out_frame_length,
  output logic [mrfc_pkg::CRC_W-1:0]      out_computed_crc
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAME + 2);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME + 1);
  localparam logic [CNT_W-1:0] CNT_LIM = CNT_W'(MAX_FRAME);
  localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(3);
  localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

  typedef struct packed {
    mrfc_pkg::verdict_t               verdict;
    logic [mrfc_pkg::LEN_W-1:0]       length;
    logic [mrfc_pkg::CRC_W-1:0]       crc;
  } result_t;

  logic [mrfc_pkg::BYTE_W-1:0] own_addr_r;
  logic [mrfc_pkg::CRC_W-1:0]  crc_r,  crc_nxt;
  logic [mrfc_pkg::BYTE_W-1:0] held0_r, held0_nxt;
  logic [mrfc_pkg::BYTE_W-1:0] held1_r, held1_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [mrfc_pkg::BYTE_W-1:0] addr_r, addr_nxt;

  logic    out_valid_r, skid_valid_r;
  result_t out_r, skid_r;
  result_t res_nxt;

  logic in_acc, out_take, res_new;
  logic [CNT_W-1:0] len_sat;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid & ~skid_valid_r;
  assign out_take = out_valid_r & ~out_stall;
  assign res_new  = in_acc & in_last_byte;

  // frame state update for the beat on the input
  always_comb begin
    addr_nxt  = (count_r == '0) ? in_data_byte : addr_r;
    crc_nxt   = (count_r >= CNT_TWO) ? mrfc_pkg::crc16_byte(crc_r, held0_r) : crc_r;
    held0_nxt = held1_r;
    held1_nxt = in_data_byte;
    count_nxt = (count_r < CNT_MAX) ? count_r + CNT_W'(1) : count_r;
    len_sat   = (count_nxt > CNT_LIM) ? CNT_LIM : count_nxt;

    if (count_nxt < CNT_MIN || count_nxt > CNT_LIM) begin
      res_nxt.verdict = mrfc_pkg::VERDICT_LEN_ERR;
    end else if (crc_nxt[7:0] != held0_nxt || crc_nxt[15:8] != held1_nxt) begin
      res_nxt.verdict = mrfc_pkg::VERDICT_CRC_ERR;
    end else if (addr_nxt != own_addr_r) begin
      res_nxt.verdict = mrfc_pkg::VERDICT_ADDR_ERR;
    end else begin
      res_nxt.verdict = mrfc_pkg::VERDICT_OK;
    end
    res_nxt.length = mrfc_pkg::LEN_W'(len_sat);
    res_nxt.crc    = crc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r <= mrfc_pkg::OWN_ADDR_RST;
    end else if (cfg_wr_en) begin
      own_addr_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= mrfc_pkg::CRC_INIT;
      held0_r <= '0;
      held1_r <= '0;
      count_r <= '0;
      addr_r  <= '0;
    end else if (in_acc) begin
      if (in_last_byte) begin
        crc_r   <= mrfc_pkg::CRC_INIT;
        held0_r <= '0;
        held1_r <= '0;
        count_r <= '0;
        addr_r  <= '0;
      end else begin
        crc_r   <= crc_nxt;
        held0_r <= held0_nxt;
        held1_r <= held1_nxt;
        count_r <= count_nxt;
        addr_r  <= addr_nxt;
      end
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (res_new) begin
      if (!out_valid_r || out_take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (res_new) begin
      if (!out_valid_r || out_take) begin
        out_r <= res_nxt;
      end else begin
        skid_r <= res_nxt;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_verdict      = out_r.verdict;
  assign out_frame_length = out_r.length;
  assign out_computed_crc = out_r.crc;

  `MRFC_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r, "skid full with empty output")
  `MRFC_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_MAX, "byte count past saturation")
  `MRFC_ASSERT_NEXT(a_frame_cleared, res_new, count_r == '0 && crc_r == mrfc_pkg::CRC_INIT, "frame state not cleared after last beat")
  `MRFC_ASSERT_NEXT(a_skid_catch, res_new && out_valid_r && out_stall, skid_valid_r, "verdict lost while output stalled")

endmodule
